FILE: hdl/ebalu_pkg.sv
// ----------------------------------------------------------------------------
// ebalu_pkg
// Types and operation codes shared by the eight-bit cpu alu and its core.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  localparam int unsigned CmdW = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 6'd0,
    CMD_ADC    = 6'd1,
    CMD_SUB    = 6'd2,
    CMD_SBC    = 6'd3,
    CMD_AND    = 6'd4,
    CMD_XOR    = 6'd5,
    CMD_OR     = 6'd6,
    CMD_CP     = 6'd7,
    CMD_INC8   = 6'd8,
    CMD_DEC8   = 6'd9,
    CMD_INC16  = 6'd10,
    CMD_DEC16  = 6'd11,
    CMD_ADD16  = 6'd12,
    CMD_ADDSP  = 6'd13,
    CMD_DAA    = 6'd14,
    CMD_CPL    = 6'd15,
    CMD_SCF    = 6'd16,
    CMD_CCF    = 6'd17,
    CMD_RLCA   = 6'd18,
    CMD_RRCA   = 6'd19,
    CMD_RLA    = 6'd20,
    CMD_RRA    = 6'd21,
    CMD_RLC    = 6'd22,
    CMD_RRC    = 6'd23,
    CMD_RL     = 6'd24,
    CMD_RR     = 6'd25,
    CMD_SLA    = 6'd26,
    CMD_SRA    = 6'd27,
    CMD_SWAP   = 6'd28,
    CMD_SRL    = 6'd29,
    CMD_BIT    = 6'd30,
    CMD_RES    = 6'd31,
    CMD_SET    = 6'd32
  } cmd_e;

  // flag positions in the z n h c nibble
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [15:0]     operand_a;
    logic [15:0]     operand_b;
    logic [2:0]      bit_index;
    logic [3:0]      flags_in;
  } in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        write_back;
  } out_t;

endpackage

FILE: hdl/ebalu_core.sv
// ----------------------------------------------------------------------------
// ebalu_core
// Single-pass alu datapath: result, new flags and write-back for one request.
// ----------------------------------------------------------------------------
module ebalu_core (
  input  ebalu_pkg::in_t  req_i,
  output ebalu_pkg::out_t rsp_o
);

  logic [15:0] a16, b16;
  logic [7:0]  a, b;
  logic        zi, ni, hi, ci;

  logic [8:0]  add_s, adc_s;
  logic [4:0]  add_h, adc_h;
  logic [7:0]  sub_r, sbc_r;
  logic        sub_h, sub_c, sbc_h, sbc_c;
  logic [16:0] add16_s;
  logic [12:0] add16_h;
  logic [15:0] sp_s;
  logic [4:0]  sp_h;
  logic [8:0]  sp_c;
  logic        daa_lo, daa_hi;
  logic [7:0]  daa_u, daa_r;
  logic [7:0]  bit_mask;

  logic [15:0] res;
  logic [3:0]  fo;
  logic        wb;

  assign a16 = req_i.operand_a;
  assign b16 = req_i.operand_b;
  assign a   = a16[7:0];
  assign b   = b16[7:0];
  assign zi  = req_i.flags_in[ebalu_pkg::FlagZ];
  assign ni  = req_i.flags_in[ebalu_pkg::FlagN];
  assign hi  = req_i.flags_in[ebalu_pkg::FlagH];
  assign ci  = req_i.flags_in[ebalu_pkg::FlagC];

  assign add_s = {1'b0, a} + {1'b0, b};
  assign add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]};
  assign adc_s = {1'b0, a} + {1'b0, b} + {8'd0, ci};
  assign adc_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};

  assign sub_r = a - b;
  assign sub_h = a[3:0] < b[3:0];
  assign sub_c = a < b;
  assign sbc_r = a - b - {7'd0, ci};
  assign sbc_h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, ci});
  assign sbc_c = {1'b0, a} < ({1'b0, b} + {8'd0, ci});

  assign add16_s = {1'b0, a16} + {1'b0, b16};
  assign add16_h = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};

  assign sp_s = a16 + {{8{b[7]}}, b};
  assign sp_h = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_c = {1'b0, a16[7:0]} + {1'b0, b};

  assign daa_lo = hi || (!ni && (a[3:0] > ebalu_pkg::DaaLoLimit));
  assign daa_hi = ci || (!ni && (a > ebalu_pkg::DaaHiLimit));
  assign daa_u  = (daa_lo ? ebalu_pkg::DaaLoAdj : 8'd0) | (daa_hi ? ebalu_pkg::DaaHiAdj : 8'd0);
  assign daa_r  = ni ? (a - daa_u) : (a + daa_u);

  assign bit_mask = 8'd1 << req_i.bit_index;

  always_comb begin
    res = '0;
    fo  = req_i.flags_in;
    wb  = 1'b1;
    unique case (ebalu_pkg::cmd_e'(req_i.cmd))
      ebalu_pkg::CMD_ADD: begin
        res = {8'd0, add_s[7:0]};
        fo  = {add_s[7:0] == 8'd0, 1'b0, add_h[4], add_s[8]};
      end
      ebalu_pkg::CMD_ADC: begin
        res = {8'd0, adc_s[7:0]};
        fo  = {adc_s[7:0] == 8'd0, 1'b0, adc_h[4], adc_s[8]};
      end
      ebalu_pkg::CMD_SUB: begin
        res = {8'd0, sub_r};
        fo  = {sub_r == 8'd0, 1'b1, sub_h, sub_c};
      end
      ebalu_pkg::CMD_SBC: begin
        res = {8'd0, sbc_r};
        fo  = {sbc_r == 8'd0, 1'b1, sbc_h, sbc_c};
      end
      ebalu_pkg::CMD_AND: begin
        res = {8'd0, a & b};
        fo  = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ebalu_pkg::CMD_XOR: begin
        res = {8'd0, a ^ b};
        fo  = {(a ^ b) == 8'd0, 3'b000};
      end
      ebalu_pkg::CMD_OR: begin
        res = {8'd0, a | b};
        fo  = {(a | b) == 8'd0, 3'b000};
      end
      ebalu_pkg::CMD_CP: begin
        wb = 1'b0;
        fo = {sub_r == 8'd0, 1'b1, sub_h, sub_c};
      end
      ebalu_pkg::CMD_INC8: begin
        res = {8'd0, a + 8'd1};
        fo  = {(a + 8'd1) == 8'd0, 1'b0, a[3:0] == 4'hF, ci};
      end
      ebalu_pkg::CMD_DEC8: begin
        res = {8'd0, a - 8'd1};
        fo  = {(a - 8'd1) == 8'd0, 1'b1, a[3:0] == 4'h0, ci};
      end
      ebalu_pkg::CMD_INC16: res = a16 + 16'd1;
      ebalu_pkg::CMD_DEC16: res = a16 - 16'd1;
      ebalu_pkg::CMD_ADD16: begin
        res = add16_s[15:0];
        fo  = {zi, 1'b0, add16_h[12], add16_s[16]};
      end
      ebalu_pkg::CMD_ADDSP: begin
        res = sp_s;
        fo  = {2'b00, sp_h[4], sp_c[8]};
      end
      ebalu_pkg::CMD_DAA: begin
        res = {8'd0, daa_r};
        fo  = {daa_r == 8'd0, ni, 1'b0, daa_hi};
      end
      ebalu_pkg::CMD_CPL: begin
        res = {8'd0, ~a};
        fo  = {zi, 1'b1, 1'b1, ci};
      end
      ebalu_pkg::CMD_SCF: begin
        wb = 1'b0;
        fo = {zi, 3'b001};
      end
      ebalu_pkg::CMD_CCF: begin
        wb = 1'b0;
        fo = {zi, 2'b00, !ci};
      end
      ebalu_pkg::CMD_RLCA: begin
        res = {8'd0, a[6:0], a[7]};
        fo  = {3'b000, a[7]};
      end
      ebalu_pkg::CMD_RRCA: begin
        res = {8'd0, a[0], a[7:1]};
        fo  = {3'b000, a[0]};
      end
      ebalu_pkg::CMD_RLA: begin
        res = {8'd0, a[6:0], ci};
        fo  = {3'b000, a[7]};
      end
      ebalu_pkg::CMD_RRA: begin
        res = {8'd0, ci, a[7:1]};
        fo  = {3'b000, a[0]};
      end
      ebalu_pkg::CMD_RLC: begin
        res = {8'd0, a[6:0], a[7]};
        fo  = {a == 8'd0, 2'b00, a[7]};
      end
      ebalu_pkg::CMD_RRC: begin
        res = {8'd0, a[0], a[7:1]};
        fo  = {a == 8'd0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_RL: begin
        res = {8'd0, a[6:0], ci};
        fo  = {{a[6:0], ci} == 8'd0, 2'b00, a[7]};
      end
      ebalu_pkg::CMD_RR: begin
        res = {8'd0, ci, a[7:1]};
        fo  = {{ci, a[7:1]} == 8'd0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_SLA: begin
        res = {8'd0, a[6:0], 1'b0};
        fo  = {a[6:0] == 7'd0, 2'b00, a[7]};
      end
      ebalu_pkg::CMD_SRA: begin
        res = {8'd0, a[7], a[7:1]};
        fo  = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_SWAP: begin
        res = {8'd0, a[3:0], a[7:4]};
        fo  = {a == 8'd0, 3'b000};
      end
      ebalu_pkg::CMD_SRL: begin
        res = {8'd0, 1'b0, a[7:1]};
        fo  = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_BIT: begin
        wb = 1'b0;
        fo = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, ci};
      end
      ebalu_pkg::CMD_RES: res = {8'd0, a & ~bit_mask};
      ebalu_pkg::CMD_SET: res = {8'd0, a | bit_mask};
      default: begin
        res = '0;
        fo  = req_i.flags_in;
        wb  = 1'b0;
      end
    endcase
  end

  assign rsp_o.result     = res;
  assign rsp_o.flags_out  = fo;
  assign rsp_o.write_back = wb;

endmodule

FILE: hdl/eight_bit_cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// Game Boy style execute-stage alu with z n h c flags.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless the input stalls; its result passes
// the input register, then the result register, so throughput is one request
// per clock while nothing stalls. The single combinational pass of the alu
// core between the two registers sets that rate. When the result side stalls
// with both stages full, the input side stalls in the same cycle.
module eight_bit_cpu_alu_with_flags (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ebalu_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ebalu_pkg::out_t out_data_o
);

  logic            s1_valid_q, s1_valid_d;
  logic            s2_valid_q, s2_valid_d;
  ebalu_pkg::in_t  s1_q;
  ebalu_pkg::out_t s2_q;
  ebalu_pkg::out_t core_rsp;
  logic            in_accept;
  logic            s2_adv;

  assign s2_adv     = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && s2_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_accept || (s1_valid_q && !s2_adv);
  assign s2_valid_d = s2_adv || (s2_valid_q && out_stall_i);

  ebalu_core u_core (
    .req_i (s1_q),
    .rsp_o (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (s2_adv) begin
      s2_q <= core_rsp;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

  // input stall only when the result stage is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result stage could drain");

  // an accepted request occupies the input stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted request lost from input stage");

  // results that are not written back carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.write_back) |-> (out_data_o.result == 16'd0))
    else $error("non write-back result is not zero");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eight-bit cpu alu with flags. A queue of
// requests (directed corners, then random mixes with BCD-shaped DAA inputs)
// feeds a clocked driver with random gaps; a clocked monitor with random
// stalls compares every result against an in-bench model of the alu.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomReqs = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ebalu_pkg::in_t  in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ebalu_pkg::out_t out_data;

  ebalu_pkg::in_t  pending_q [$];
  ebalu_pkg::out_t expected_q [$];
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic in_quiet = 1'b0;
  logic out_quiet = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  eight_bit_cpu_alu_with_flags dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  function automatic ebalu_pkg::out_t alu_predict(ebalu_pkg::in_t req);
    logic [31:0] a, b, a16, b16, t, u, res, bidx;
    logic zi, ni, hi, ci;
    logic [3:0] fo;
    logic wb;
    ebalu_pkg::out_t o;
    a16 = 32'(req.operand_a);
    b16 = 32'(req.operand_b);
    a = a16 & 32'hFF;
    b = b16 & 32'hFF;
    bidx = 32'(req.bit_index);
    zi = req.flags_in[ebalu_pkg::FlagZ];
    ni = req.flags_in[ebalu_pkg::FlagN];
    hi = req.flags_in[ebalu_pkg::FlagH];
    ci = req.flags_in[ebalu_pkg::FlagC];
    res = 0;
    fo = req.flags_in;
    wb = 1'b1;
    case (req.cmd)
      ebalu_pkg::CMD_ADD: begin
        t = a + b;
        res = t & 32'hFF;
        fo = {res == 0, 1'b0, (a & 32'hF) + (b & 32'hF) > 32'hF, t > 32'hFF};
      end
      ebalu_pkg::CMD_ADC: begin
        t = a + b + ci;
        res = t & 32'hFF;
        fo = {res == 0, 1'b0, (a & 32'hF) + (b & 32'hF) + ci > 32'hF, t > 32'hFF};
      end
      ebalu_pkg::CMD_SUB: begin
        res = (a - b) & 32'hFF;
        fo = {res == 0, 1'b1, (a & 32'hF) < (b & 32'hF), a < b};
      end
      ebalu_pkg::CMD_SBC: begin
        res = (a - b - ci) & 32'hFF;
        fo = {res == 0, 1'b1, (a & 32'hF) < (b & 32'hF) + ci, a < b + ci};
      end
      ebalu_pkg::CMD_AND: begin
        res = a & b;
        fo = {res == 0, 1'b0, 1'b1, 1'b0};
      end
      ebalu_pkg::CMD_XOR: begin
        res = a ^ b;
        fo = {res == 0, 3'b000};
      end
      ebalu_pkg::CMD_OR: begin
        res = a | b;
        fo = {res == 0, 3'b000};
      end
      ebalu_pkg::CMD_CP: begin
        t = (a - b) & 32'hFF;
        wb = 1'b0;
        fo = {t == 0, 1'b1, (a & 32'hF) < (b & 32'hF), a < b};
      end
      ebalu_pkg::CMD_INC8: begin
        res = (a + 1) & 32'hFF;
        fo = {res == 0, 1'b0, (res & 32'hF) == 0, ci};
      end
      ebalu_pkg::CMD_DEC8: begin
        res = (a - 1) & 32'hFF;
        fo = {res == 0, 1'b1, (res & 32'hF) == 32'hF, ci};
      end
      ebalu_pkg::CMD_INC16: res = (a16 + 1) & 32'hFFFF;
      ebalu_pkg::CMD_DEC16: res = (a16 - 1) & 32'hFFFF;
      ebalu_pkg::CMD_ADD16: begin
        t = a16 + b16;
        res = t & 32'hFFFF;
        fo = {zi, 1'b0, (a16 & 32'hFFF) + (b16 & 32'hFFF) >= 32'h1000, t >= 32'h10000};
      end
      ebalu_pkg::CMD_ADDSP: begin
        u = b[7] ? (b | 32'hFF00) : b;
        res = (a16 + u) & 32'hFFFF;
        fo = {2'b00, (a16 & 32'hF) + (b & 32'hF) >= 32'h10, (a16 & 32'hFF) + b >= 32'h100};
      end
      ebalu_pkg::CMD_DAA: begin
        u = 0;
        t = 0;
        if (hi || (!ni && (a & 32'hF) > 32'(ebalu_pkg::DaaLoLimit)))
          u = 32'(ebalu_pkg::DaaLoAdj);
        if (ci || (!ni && a > 32'(ebalu_pkg::DaaHiLimit))) begin
          u = u | 32'(ebalu_pkg::DaaHiAdj);
          t = 1;
        end
        res = (ni ? (a - u) : (a + u)) & 32'hFF;
        fo = {res == 0, ni, 1'b0, t[0]};
      end
      ebalu_pkg::CMD_CPL: begin
        res = ~a & 32'hFF;
        fo = {zi, 1'b1, 1'b1, ci};
      end
      ebalu_pkg::CMD_SCF: begin
        wb = 1'b0;
        fo = {zi, 3'b001};
      end
      ebalu_pkg::CMD_CCF: begin
        wb = 1'b0;
        fo = {zi, 2'b00, !ci};
      end
      ebalu_pkg::CMD_RLCA: begin
        res = ((a << 1) | (a >> 7)) & 32'hFF;
        fo = {3'b000, a[7]};
      end
      ebalu_pkg::CMD_RRCA: begin
        res = ((a >> 1) | (a << 7)) & 32'hFF;
        fo = {3'b000, a[0]};
      end
      ebalu_pkg::CMD_RLA: begin
        res = ((a << 1) | ci) & 32'hFF;
        fo = {3'b000, a[7]};
      end
      ebalu_pkg::CMD_RRA: begin
        res = ((a >> 1) | (32'(ci) << 7)) & 32'hFF;
        fo = {3'b000, a[0]};
      end
      ebalu_pkg::CMD_RLC: begin
        res = ((a << 1) | (a >> 7)) & 32'hFF;
        fo = {res == 0, 2'b00, a[7]};
      end
      ebalu_pkg::CMD_RRC: begin
        res = ((a >> 1) | (a << 7)) & 32'hFF;
        fo = {res == 0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_RL: begin
        res = ((a << 1) | ci) & 32'hFF;
        fo = {res == 0, 2'b00, a[7]};
      end
      ebalu_pkg::CMD_RR: begin
        res = ((a >> 1) | (32'(ci) << 7)) & 32'hFF;
        fo = {res == 0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_SLA: begin
        res = (a << 1) & 32'hFF;
        fo = {res == 0, 2'b00, a[7]};
      end
      ebalu_pkg::CMD_SRA: begin
        res = (a >> 1) | (a & 32'h80);
        fo = {res == 0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_SWAP: begin
        res = ((a >> 4) | (a << 4)) & 32'hFF;
        fo = {res == 0, 3'b000};
      end
      ebalu_pkg::CMD_SRL: begin
        res = a >> 1;
        fo = {res == 0, 2'b00, a[0]};
      end
      ebalu_pkg::CMD_BIT: begin
        wb = 1'b0;
        fo = {((a >> bidx) & 1) == 0, 1'b0, 1'b1, ci};
      end
      ebalu_pkg::CMD_RES: res = a & ~(32'd1 << bidx) & 32'hFF;
      ebalu_pkg::CMD_SET: res = (a | (32'd1 << bidx)) & 32'hFF;
      default: begin
        res = 0;
        fo = req.flags_in;
        wb = 1'b0;
      end
    endcase
    o.result = res[15:0];
    o.flags_out = fo;
    o.write_back = wb;
    return o;
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      3: return 16'h0080;
      4: return 16'h007F;
      5: return 16'h0FFF;
      6: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  function automatic ebalu_pkg::in_t random_req();
    ebalu_pkg::in_t req, prior;
    ebalu_pkg::out_t prior_res;
    if ($urandom_range(0, 9) == 0) req.cmd = 6'($urandom_range(33, 63));
    else req.cmd = 6'($urandom_range(0, 32));
    req.operand_a = pick_operand();
    req.operand_b = pick_operand();
    req.bit_index = 3'($urandom_range(0, 7));
    req.flags_in = 4'($urandom_range(0, 15));
    // daa mostly follows a real bcd add or subtract
    if (req.cmd == ebalu_pkg::CMD_DAA && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: prior.cmd = ebalu_pkg::CMD_ADD;
        1: prior.cmd = ebalu_pkg::CMD_ADC;
        2: prior.cmd = ebalu_pkg::CMD_SUB;
        default: prior.cmd = ebalu_pkg::CMD_SBC;
      endcase
      prior.operand_a = {8'($urandom_range(0, 255)), pick_bcd()};
      prior.operand_b = {8'($urandom_range(0, 255)), pick_bcd()};
      prior.bit_index = req.bit_index;
      prior.flags_in = 4'($urandom_range(0, 15));
      prior_res = alu_predict(prior);
      req.operand_a = {req.operand_a[15:8], prior_res.result[7:0]};
      req.flags_in = prior_res.flags_out;
    end
    return req;
  endfunction

  task automatic queue_req(logic [5:0] cmd, logic [15:0] a, logic [15:0] b,
                           logic [2:0] bidx, logic [3:0] fl);
    ebalu_pkg::in_t req;
    req.cmd = cmd;
    req.operand_a = a;
    req.operand_b = b;
    req.bit_index = bidx;
    req.flags_in = fl;
    pending_q.push_back(req);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // request driver
  always @(posedge clk or negedge rst_n) begin
    int unsigned w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(alu_predict(in_req));
        if ($urandom_range(0, 29) == 0) in_quiet <= !in_quiet;
        w = in_quiet ? 0 : $urandom_range(0, 18);
        if (w == 0 && pending_q.size() != 0) begin
          in_req <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          gap_left <= (w == 0) ? 0 : w - 1;
        end
      end else if (!in_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          in_valid <= 1'b1;
          in_req <= pending_q.pop_front();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk or negedge rst_n) begin
    ebalu_pkg::out_t want;
    int unsigned w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.result !== want.result) begin
            $display("%0t: result mismatch, expected %h actual %h",
                     $time, want.result, out_data.result);
            fail_count++;
          end
          if (out_data.flags_out !== want.flags_out) begin
            $display("%0t: flags mismatch, expected %b actual %b",
                     $time, want.flags_out, out_data.flags_out);
            fail_count++;
          end
          if (out_data.write_back !== want.write_back) begin
            $display("%0t: write_back mismatch, expected %b actual %b",
                     $time, want.write_back, out_data.write_back);
            fail_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) out_quiet <= !out_quiet;
        w = out_quiet ? 0 : $urandom_range(0, 18);
        out_stall <= (w != 0);
        hold_left <= (w == 0) ? 0 : w - 1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("eight_bit_cpu_alu_with_flags verification failed");
      $finish;
    end
  end

  initial begin
    // every operation once, operands walking through the corners
    for (int i = 0; i <= 32; i++) begin
      case (i % 4)
        0: queue_req(6'(i), 16'h0000, 16'h0000, 3'(i), 4'h0);
        1: queue_req(6'(i), 16'hFFFF, 16'hFFFF, 3'(i), 4'hF);
        2: queue_req(6'(i), 16'h0F80, 16'hF00F, 3'(i), 4'(i));
        default: queue_req(6'(i), 16'h807F, 16'h7F81, 3'd7, 4'(i));
      endcase
    end
    // sbc whose 8-bit result is zero only through the carry
    queue_req(ebalu_pkg::CMD_SBC, 16'h0010, 16'h000F, 3'd0, 4'b0001);
    // sp add with a negative offset, then with a positive offset that wraps to zero
    queue_req(ebalu_pkg::CMD_ADDSP, 16'h0000, 16'h00FF, 3'd0, 4'hF);
    queue_req(ebalu_pkg::CMD_ADDSP, 16'hFFF8, 16'h0008, 3'd0, 4'h0);
    // daa after a subtract with half carry, then after an add with no flags set
    queue_req(ebalu_pkg::CMD_DAA, 16'h000F, 16'h0000, 3'd0, 4'b0110);
    queue_req(ebalu_pkg::CMD_DAA, 16'h009A, 16'h0000, 3'd0, 4'b0000);
    // unassigned codes
    queue_req(6'd33, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
    queue_req(6'd63, 16'h1234, 16'h5678, 3'd3, 4'hA);
    for (int i = 0; i < RandomReqs; i++) pending_q.push_back(random_req());

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    do @(posedge clk);
    while (!(pending_q.size() == 0 && !in_valid && expected_q.size() == 0));
    repeat (DrainCycles) @(posedge clk);

    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("eight_bit_cpu_alu_with_flags verification clean");
    end else begin
      $display("eight_bit_cpu_alu_with_flags verification failed");
    end
    $finish;
  end

endmodule
